[src/arpc_pkg.sv]
// Shared types and codes for the ARP cache with retry queue.
package arpc_pkg;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_HIT     = 3'd0,
    KIND_MISS    = 3'd1,
    KIND_UPDATED = 3'd2,
    KIND_REQUEST = 3'd3,
    KIND_IDLE    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_EXPIRE  = 2'd0,
    REG_REFRESH = 2'd1,
    REG_GAP     = 2'd2,
    REG_LIMIT   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] ip_address;
    logic [47:0] hw_address;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] result_ip;
    logic [47:0] result_mac;
    logic        table_full;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LK_SCAN,
    ST_LK_DROP,
    ST_PQ_SCAN,
    ST_UP_PSCAN,
    ST_UP_PDROP,
    ST_UP_CSCAN,
    ST_TK_SCAN,
    ST_TK_PDROP,
    ST_EMIT
  } state_t;

  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

endpackage

[src/arp_cache_with_retry_queue.sv]
// Top level: ARP cache, pending-query list and their scan sequencer.
// Steps: a lookup scans the cache; a fresh hit answers there, while a miss, an expired entry
// (shifted out) or a stale hit then scans the pending list and queues the query. An update
// drops matching queries, then scans the cache; a tick scans the queries, dropping spent ones.
// Throughput: one item in work at a time; ready returns once its last result has left.
// Reset (synchronous): lists empty, time zero, registers to defaults; no clearing pass.
`default_nettype none
module arp_cache_with_retry_queue #(
  parameter int CACHE_DEPTH   = 16,
  parameter int PENDING_DEPTH = 8
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  arpc_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output arpc_pkg::out_item_t   out_data,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire [1:0]             cfg_index,
  input  wire [15:0]            cfg_data
);
  import arpc_pkg::*;

  localparam int CW = $clog2(CACHE_DEPTH);
  localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  // configuration
  logic [15:0] expire_ticks, refresh_ticks, retry_gap_ticks;
  logic [3:0]  retry_limit;

  // storage
  logic [31:0] cache_ip   [CACHE_DEPTH];
  logic [47:0] cache_mac  [CACHE_DEPTH];
  logic [47:0] cache_stamp[CACHE_DEPTH];
  logic [31:0] pend_ip    [PENDING_DEPTH];
  logic [47:0] pend_due   [PENDING_DEPTH];
  logic [3:0]  pend_tries [PENDING_DEPTH];
  logic [CW:0] cache_used, cache_used_next;
  logic [PW:0] pend_used, pend_used_next;
  logic [47:0] now_ticks, now_ticks_next;

  // sequencer registers
  state_t      state, state_next;
  logic [31:0] ip, ip_next;
  logic [47:0] mac, mac_next;
  logic [CW:0] ci, ci_next;          // cache scan / shift index
  logic [PW:0] pi, pi_next;          // pending scan / shift index
  logic [PW:0] drop_pi, drop_pi_next; // where a removal started, scan resumes there
  logic        miss_path, miss_path_next; // lookup: 1 miss, 0 stale hit needing query
  logic [47:0] hit_mac, hit_mac_next;
  logic        any_req, any_req_next;     // a tick request is held back
  logic [31:0] held_ip, held_ip_next;     // target of the held request

  // output register
  out_item_t   obuf, obuf_next;
  logic        ovalid, ovalid_next;

  // entry write strobes, always at the scan index
  logic        c_wr;
  logic [31:0] c_wr_ip;
  logic [47:0] c_wr_mac, c_wr_stamp;
  logic        p_wr;
  logic [31:0] p_wr_ip;
  logic [47:0] p_wr_due;
  logic [3:0]  p_wr_tries;

  assign cfg_ready = 1'b1;
  assign out_valid = ovalid;
  assign out_data  = obuf;
  assign in_ready  = (state == ST_IDLE) && !ovalid;

  wire out_free = !ovalid || out_ready;
  wire cache_room = cache_used < (CW+1)'(CACHE_DEPTH);
  wire pend_room  = pend_used < (PW+1)'(PENDING_DEPTH);

  // shared compare unit: address equality of the entry under the scan index
  wire [CW-1:0] cidx   = ci[CW-1:0];
  wire [PW-1:0] pidx   = pi[PW-1:0];
  wire [CW-1:0] cidx_n = cidx + 1'b1;
  wire [PW-1:0] pidx_n = pidx + 1'b1;
  wire c_eq = (cache_ip[cidx] == ip);
  wire p_eq = (pend_ip[pidx] == ip);
  wire [47:0] age = now_ticks - cache_stamp[cidx];
  wire [48:0] due_sum = {1'b0, now_ticks} + {33'd0, retry_gap_ticks};
  wire [47:0] due_new = due_sum[48] ? MAX48 : due_sum[47:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      expire_ticks    <= 16'd1200;
      refresh_ticks   <= 16'd600;
      retry_gap_ticks <= 16'd10;
      retry_limit     <= 4'd3;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_EXPIRE:  expire_ticks    <= cfg_data;
        REG_REFRESH: refresh_ticks   <= cfg_data;
        REG_GAP:     retry_gap_ticks <= cfg_data;
        REG_LIMIT:   retry_limit     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ovalid     <= 1'b0;
      obuf       <= '0;
      cache_used <= '0;
      pend_used  <= '0;
      now_ticks  <= '0;
      ip         <= '0;
      mac        <= '0;
      ci         <= '0;
      pi         <= '0;
      drop_pi    <= '0;
      miss_path  <= 1'b0;
      hit_mac    <= '0;
      any_req    <= 1'b0;
      held_ip    <= '0;
    end else begin
      state      <= state_next;
      ovalid     <= ovalid_next;
      obuf       <= obuf_next;
      cache_used <= cache_used_next;
      pend_used  <= pend_used_next;
      now_ticks  <= now_ticks_next;
      ip         <= ip_next;
      mac        <= mac_next;
      ci         <= ci_next;
      pi         <= pi_next;
      drop_pi    <= drop_pi_next;
      miss_path  <= miss_path_next;
      hit_mac    <= hit_mac_next;
      any_req    <= any_req_next;
      held_ip    <= held_ip_next;
    end
  end

  always_ff @(posedge clk) begin
    if (c_wr) begin
      cache_ip[cidx]    <= c_wr_ip;
      cache_mac[cidx]   <= c_wr_mac;
      cache_stamp[cidx] <= c_wr_stamp;
    end
    if (p_wr) begin
      pend_ip[pidx]    <= p_wr_ip;
      pend_due[pidx]   <= p_wr_due;
      pend_tries[pidx] <= p_wr_tries;
    end
  end

  always_comb begin
    state_next      = state;
    ovalid_next     = ovalid && !out_ready;
    obuf_next       = obuf;
    cache_used_next = cache_used;
    pend_used_next  = pend_used;
    now_ticks_next  = now_ticks;
    ip_next         = ip;
    mac_next        = mac;
    ci_next         = ci;
    pi_next         = pi;
    drop_pi_next    = drop_pi;
    miss_path_next  = miss_path;
    hit_mac_next    = hit_mac;
    any_req_next    = any_req;
    held_ip_next    = held_ip;
    c_wr            = 1'b0;
    c_wr_ip         = ip;
    c_wr_mac        = mac;
    c_wr_stamp      = now_ticks;
    p_wr            = 1'b0;
    p_wr_ip         = ip;
    p_wr_due        = '0;
    p_wr_tries      = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          ip_next      = in_data.ip_address;
          mac_next     = in_data.hw_address;
          ci_next      = '0;
          pi_next      = '0;
          any_req_next = 1'b0;
          case (cmd_t'(in_data.command))
            CMD_LOOKUP: state_next = ST_LK_SCAN;
            CMD_UPDATE: state_next = ST_UP_PSCAN;
            CMD_TICK: begin
              if (now_ticks != MAX48) now_ticks_next = now_ticks + 48'd1;
              state_next = ST_TK_SCAN;
            end
            default: begin
              obuf_next   = '{kind: KIND_IDLE, result_ip: '0, result_mac: '0,
                              table_full: 1'b0, last: 1'b1};
              ovalid_next = 1'b1;
            end
          endcase
        end
      end
      ST_LK_SCAN: begin
        if (ci >= cache_used) begin
          miss_path_next = 1'b1;
          hit_mac_next   = '0;
          state_next     = ST_PQ_SCAN;
        end else if (c_eq) begin
          if (age > {32'd0, expire_ticks}) begin
            state_next = ST_LK_DROP;
          end else if (age > {32'd0, refresh_ticks}) begin
            miss_path_next = 1'b0;
            hit_mac_next   = cache_mac[cidx];
            state_next     = ST_PQ_SCAN;
          end else begin
            obuf_next   = '{kind: KIND_HIT, result_ip: ip, result_mac: cache_mac[cidx],
                            table_full: 1'b0, last: 1'b1};
            ovalid_next = 1'b1;
            state_next  = ST_IDLE;
          end
        end else begin
          ci_next = ci + 1'b1;
        end
      end
      ST_LK_DROP: begin
        // close the gap one entry per cycle
        if (ci + 1'b1 < cache_used) begin
          c_wr       = 1'b1;
          c_wr_ip    = cache_ip[cidx_n];
          c_wr_mac   = cache_mac[cidx_n];
          c_wr_stamp = cache_stamp[cidx_n];
          ci_next    = ci + 1'b1;
        end else begin
          cache_used_next = cache_used - 1'b1;
          miss_path_next  = 1'b1;
          hit_mac_next    = '0;
          state_next      = ST_PQ_SCAN;
        end
      end
      ST_PQ_SCAN: begin
        if (pi < pend_used && p_eq) begin
          obuf_next   = '{kind: miss_path ? KIND_MISS : KIND_HIT, result_ip: ip,
                          result_mac: hit_mac, table_full: 1'b0, last: 1'b1};
          ovalid_next = 1'b1;
          state_next  = ST_IDLE;
        end else if (pi < pend_used) begin
          pi_next = pi + 1'b1;
        end else begin
          if (pend_room) begin
            p_wr           = 1'b1;
            pend_used_next = pend_used + 1'b1;
          end
          obuf_next   = '{kind: miss_path ? KIND_MISS : KIND_HIT, result_ip: ip,
                          result_mac: hit_mac, table_full: !pend_room, last: 1'b1};
          ovalid_next = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_UP_PSCAN: begin
        if (pi >= pend_used) begin
          state_next = ST_UP_CSCAN;
        end else if (p_eq) begin
          drop_pi_next = pi;
          state_next   = ST_UP_PDROP;
        end else begin
          pi_next = pi + 1'b1;
        end
      end
      ST_UP_PDROP, ST_TK_PDROP: begin
        if (pi + 1'b1 < pend_used) begin
          p_wr       = 1'b1;
          p_wr_ip    = pend_ip[pidx_n];
          p_wr_due   = pend_due[pidx_n];
          p_wr_tries = pend_tries[pidx_n];
          pi_next    = pi + 1'b1;
        end else begin
          pend_used_next = pend_used - 1'b1;
          pi_next        = drop_pi;
          state_next     = (state == ST_UP_PDROP) ? ST_UP_PSCAN : ST_TK_SCAN;
        end
      end
      ST_UP_CSCAN: begin
        if (ci >= cache_used) begin
          if (cache_room) begin
            c_wr            = 1'b1;
            cache_used_next = cache_used + 1'b1;
          end
          obuf_next   = '{kind: KIND_UPDATED, result_ip: ip, result_mac: '0,
                          table_full: !cache_room, last: 1'b1};
          ovalid_next = 1'b1;
          state_next  = ST_IDLE;
        end else if (c_eq) begin
          c_wr        = 1'b1;
          obuf_next   = '{kind: KIND_UPDATED, result_ip: ip, result_mac: '0,
                          table_full: 1'b0, last: 1'b1};
          ovalid_next = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          ci_next = ci + 1'b1;
        end
      end
      ST_TK_SCAN: begin
        if (pi >= pend_used) begin
          if (!any_req) begin
            obuf_next   = '{kind: KIND_IDLE, result_ip: '0, result_mac: '0,
                            table_full: 1'b0, last: 1'b1};
            ovalid_next = 1'b1;
            state_next  = ST_IDLE;
          end else if (out_free) begin
            // the held request is the last one
            obuf_next   = '{kind: KIND_REQUEST, result_ip: held_ip, result_mac: '0,
                            table_full: 1'b0, last: 1'b1};
            ovalid_next = 1'b1;
            state_next  = ST_IDLE;
          end
        end else if (now_ticks < pend_due[pidx]) begin
          pi_next = pi + 1'b1;
        end else if (pend_tries[pidx] >= retry_limit) begin
          drop_pi_next = pi;
          state_next   = ST_TK_PDROP;
        end else if (!any_req || out_free) begin
          // a later request exists, so the held one goes out with last low
          if (any_req) begin
            obuf_next   = '{kind: KIND_REQUEST, result_ip: held_ip, result_mac: '0,
                            table_full: 1'b0, last: 1'b0};
            ovalid_next = 1'b1;
          end
          held_ip_next = pend_ip[pidx];
          any_req_next = 1'b1;
          p_wr         = 1'b1;
          p_wr_ip      = pend_ip[pidx];
          p_wr_due     = due_new;
          p_wr_tries   = pend_tries[pidx] + 4'd1;
          pi_next      = pi + 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // a shown result must not change while stalled
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    cache_used <= (CW+1)'(CACHE_DEPTH) && pend_used <= (PW+1)'(PENDING_DEPTH))
    else $error("list count overflow");
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != ST_IDLE || out_valid)
    else $error("item accepted without work");
endmodule
`default_nettype wire

[test/arp_cache_with_retry_queue_test.sv]
// Randomized and directed test of the ARP cache with retry queue.
module arp_cache_with_retry_queue_test;
  import arpc_pkg::*;

  // Scoreboard: private copy of cache, pending list and registers, plus the
  // queue of results the block still owes.
  class arp_scoreboard;
    logic [15:0] expire_ticks, refresh_ticks, gap_ticks;
    logic [3:0]  retry_limit;
    logic [47:0] now_ticks;
    logic [31:0] c_ip[16];
    logic [47:0] c_mac[16];
    logic [47:0] c_stamp[16];
    bit          c_refr[16];
    int          c_used;
    logic [31:0] p_ip[8];
    logic [47:0] p_due[8];
    logic [3:0]  p_tries[8];
    int          p_used;
    out_item_t   owed[$];
    int          errors;

    function void reset_state();
      expire_ticks = 1200; refresh_ticks = 600; gap_ticks = 10; retry_limit = 3;
      now_ticks = 0; c_used = 0; p_used = 0; owed.delete(); errors = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] v);
      case (idx)
        REG_EXPIRE:  expire_ticks = v;
        REG_REFRESH: refresh_ticks = v;
        REG_GAP:     gap_ticks = v;
        REG_LIMIT:   retry_limit = v[3:0];
        default: ;
      endcase
    endfunction

    function void owe(kind_t k, logic [31:0] ip, logic [47:0] mac, bit full, bit lst);
      out_item_t r;
      r.kind = k; r.result_ip = ip; r.result_mac = mac; r.table_full = full; r.last = lst;
      owed.push_back(r);
    endfunction

    function void unlink_cache(int i);
      for (int j = i; j + 1 < c_used; j++) begin
        c_ip[j] = c_ip[j+1]; c_mac[j] = c_mac[j+1];
        c_stamp[j] = c_stamp[j+1]; c_refr[j] = c_refr[j+1];
      end
      c_used--;
    endfunction

    function void unlink_query(int i);
      for (int j = i; j + 1 < p_used; j++) begin
        p_ip[j] = p_ip[j+1]; p_due[j] = p_due[j+1]; p_tries[j] = p_tries[j+1];
      end
      p_used--;
    endfunction

    // returns 1 when the pending list was full and the query was dropped
    function bit queue_query(logic [31:0] ip);
      for (int i = 0; i < p_used; i++)
        if (p_ip[i] == ip) return 0;
      if (p_used >= 8) return 1;
      p_ip[p_used] = ip; p_due[p_used] = 0; p_tries[p_used] = 0;
      p_used++;
      return 0;
    endfunction

    function void note_item(in_item_t it);
      logic [47:0] age;
      logic [48:0] due;
      int i, n;
      bit full;
      case (cmd_t'(it.command))
        CMD_LOOKUP: begin
          for (i = 0; i < c_used; i++)
            if (c_ip[i] == it.ip_address) begin
              age = now_ticks - c_stamp[i];
              if (age > expire_ticks) begin
                unlink_cache(i);
                break;
              end
              full = 0;
              if (age > refresh_ticks) begin
                c_refr[i] = 1;
                full = queue_query(it.ip_address);
              end
              owe(KIND_HIT, it.ip_address, c_mac[i], full, 1);
              return;
            end
          owe(KIND_MISS, it.ip_address, 0, queue_query(it.ip_address), 1);
        end
        CMD_UPDATE: begin
          full = 0;
          i = 0;
          while (i < p_used)
            if (p_ip[i] == it.ip_address) unlink_query(i);
            else i++;
          for (i = 0; i < c_used; i++)
            if (c_ip[i] == it.ip_address) break;
          if (i < c_used) begin
            c_stamp[i] = now_ticks; c_refr[i] = 0; c_mac[i] = it.hw_address;
          end else if (c_used < 16) begin
            c_ip[c_used] = it.ip_address; c_mac[c_used] = it.hw_address;
            c_stamp[c_used] = now_ticks; c_refr[c_used] = 0; c_used++;
          end else full = 1;
          owe(KIND_UPDATED, it.ip_address, 0, full, 1);
        end
        CMD_TICK: begin
          n = 0;
          if (now_ticks != MAX48) now_ticks++;
          i = 0;
          while (i < p_used) begin
            if (now_ticks < p_due[i]) i++;
            else if (p_tries[i] >= retry_limit) unlink_query(i);
            else begin
              owe(KIND_REQUEST, p_ip[i], 0, 0, 0);
              n++;
              due = {1'b0, now_ticks} + gap_ticks;
              p_due[i] = due[48] ? MAX48 : due[47:0];
              p_tries[i] = p_tries[i] + 1;
              i++;
            end
          end
          if (n == 0) owe(KIND_IDLE, 0, 0, 0, 1);
          else owed[owed.size()-1].last = 1;
        end
        default: owe(KIND_IDLE, 0, 0, 0, 1);
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = owed.pop_front();
      if (got.kind !== exp_r.kind)
        $display("%0t: kind exp %0d got %0d", $time, exp_r.kind, got.kind);
      if (got.result_ip !== exp_r.result_ip)
        $display("%0t: ip exp %h got %h", $time, exp_r.result_ip, got.result_ip);
      if (got.result_mac !== exp_r.result_mac)
        $display("%0t: mac exp %h got %h", $time, exp_r.result_mac, got.result_mac);
      if (got.table_full !== exp_r.table_full)
        $display("%0t: full exp %b got %b", $time, exp_r.table_full, got.table_full);
      if (got.last !== exp_r.last)
        $display("%0t: last exp %b got %b", $time, exp_r.last, got.last);
      if (got !== exp_r) errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_item_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;

  arp_cache_with_retry_queue dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  arp_scoreboard sb = new();
  bit calm;          // no idling in the closing stretch
  bit rx_enable;     // never read; the receiver's random idling hangs on calm instead

  // Address pool kept small so lookups hit, updates refresh and lists fill.
  logic [31:0] ip_pool[24];

  // Receiver: random stall bursts, results checked at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin
    int burst;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 9);
        out_ready <= 0;
        repeat (burst) @(negedge clk);
      end
      out_ready <= 1;
      @(negedge clk);
    end
  end

  // Send one item: valid held with fixed payload until accepted.
  task automatic send_item(cmd_t c, logic [31:0] ip, logic [47:0] mac);
    in_item_t it;
    if (!calm && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 9)) @(negedge clk);
    it.command = c; it.ip_address = ip; it.hw_address = mac;
    in_data = it;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    @(negedge clk);
    in_valid = 0;
  endtask

  // Wait until every owed result arrived, then a margin for a busy sequencer.
  task automatic drain();
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] v);
    cfg_index = idx;
    cfg_data = v;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic random_item();
    int r;
    logic [31:0] ip;
    logic [47:0] mac;
    r = $urandom_range(0, 99);
    ip = ip_pool[$urandom_range(0, 23)];
    mac = 48'({$urandom, $urandom});
    if (r < 3) send_item(CMD_NONE, $urandom, mac);
    else if (r < 8) send_item(CMD_LOOKUP, $urandom, mac);
    else if (r < 40) send_item(CMD_LOOKUP, ip, mac);
    else if (r < 65) send_item(CMD_UPDATE, ip, mac);
    else send_item(CMD_TICK, $urandom, mac);
  endtask

  task automatic run_phase(int count, logic [15:0] ex, logic [15:0] rf,
                           logic [15:0] gp, logic [3:0] lim);
    drain();
    write_reg(REG_EXPIRE, ex);
    write_reg(REG_REFRESH, rf);
    write_reg(REG_GAP, gp);
    write_reg(REG_LIMIT, {12'd0, lim});
    repeat (count) random_item();
  endtask

  initial begin
    sb.reset_state();
    for (int i = 0; i < 24; i++) ip_pool[i] = $urandom;
    ip_pool[0] = 32'h0000_0000;
    ip_pool[1] = 32'hFFFF_FFFF;
    repeat (11) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: extremes, every command, stale/expired hits, full lists.
    send_item(CMD_LOOKUP, 32'h0, 48'h0);                     // miss, queued
    send_item(CMD_UPDATE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0);             // fresh hit
    send_item(CMD_TICK, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);   // request for 0
    send_item(CMD_NONE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);   // meaningless cmd
    drain();
    write_reg(REG_EXPIRE, 16'd3);
    write_reg(REG_REFRESH, 16'd1);
    write_reg(REG_GAP, 16'd1);
    write_reg(REG_LIMIT, 16'd15);
    repeat (2) send_item(CMD_TICK, 0, 0);
    send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 0);                 // stale hit
    repeat (3) send_item(CMD_TICK, 0, 0);
    send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 0);                 // expired
    for (int i = 0; i < 9; i++) send_item(CMD_LOOKUP, 32'h100 + i, 0); // pending full
    send_item(CMD_TICK, 0, 0);                               // seven requests

    // Hold off until the block is empty of owed results.
    drain();
    write_reg(REG_LIMIT, 16'd0);
    send_item(CMD_TICK, 0, 0);                               // all due queries dropped
    for (int i = 0; i < 17; i++)
      send_item(CMD_UPDATE, 32'h200 + i, 48'({$urandom, $urandom}));

    // Random phases over several register settings.
    run_phase(60, 16'd65535, 16'd65535, 16'd65535, 4'd15);
    run_phase(70, 16'd6, 16'd2, 16'd1, 4'd2);
    run_phase(60, 16'd1, 16'd1, 16'd2, 4'd1);
    run_phase(60, 16'd20, 16'd5, 16'd3, 4'd4);
    drain();
    calm = 1;
    repeat (25) random_item();
    drain();
    if (sb.errors == 0 && sb.owed.size() == 0)
      $display("arp_cache_with_retry_queue_test OK");
    else
      $display("arp_cache_with_retry_queue_test NOT OK");
    $finish;
  end

  initial begin
    #5000000;
    $display("arp_cache_with_retry_queue_test NOT OK");
    $finish;
  end
endmodule
